/* sv/rectangle_subtract_assert.svh */
// Assertion macros used by the rectangle subtract serializer.
`ifndef RECTANGLE_SUBTRACT_ASSERT_SVH
`define RECTANGLE_SUBTRACT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rectangle_subtract: assertion failed");

// Next-cycle implication, disabled during reset.
`define RS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rectangle_subtract: assertion failed");

`endif

/* sv/rect_sub_pkg.sv */
// Types shared by the rectangle subtract pipeline.
`timescale 1ns / 1ps

package rect_sub_pkg;

  typedef enum logic [2:0] {
    KindWhole = 3'd0,
    KindLeft  = 3'd1,
    KindRight = 3'd2,
    KindLower = 3'd3,
    KindUpper = 3'd4
  } piece_kind_e;

  typedef struct packed {
    logic empty;
    logic upper;
    logic lower;
    logic right;
    logic left;
    logic whole;
  } piece_mask_t;

endpackage

/* sv/rectangle_subtract.sv */
// Rectangle subtract: top level with input and compare stages.
//
// Usage: each input transaction on in_valid_i/in_ready_o carries rectangles A
// and B. The block returns the parts of A outside B as one to four result
// transactions on out_valid_o/out_ready_i, in the order left, right, lower,
// upper strip; A comes back whole when the rectangles do not overlap, and a
// single result with empty_res_o set when B covers A. last_o marks the final
// result of each input.
// Path: input stage, compare stage, piece serializer and output register;
// pieces after the first follow one per cycle while out_ready_i is high.
// Throughput: one input per cycle when each yields one result; an input with
// several pieces holds the serializer until its last piece leaves, so the rate
// is set by the number of pieces emitted through the single output register.
// Reset: rst_ni clears all valid bits; the pipeline starts empty.
// Stall: when out_ready_i is low the output register holds its result and
// the stages behind it fill and then drop in_ready_o; nothing is lost.
`timescale 1ns / 1ps

module rectangle_subtract import rect_sub_pkg::*; #(
  parameter int unsigned CoordWidth = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CoordWidth-1:0] a_x1_i,
  input  logic signed [CoordWidth-1:0] a_y1_i,
  input  logic signed [CoordWidth-1:0] a_x2_i,
  input  logic signed [CoordWidth-1:0] a_y2_i,
  input  logic signed [CoordWidth-1:0] b_x1_i,
  input  logic signed [CoordWidth-1:0] b_y1_i,
  input  logic signed [CoordWidth-1:0] b_x2_i,
  input  logic signed [CoordWidth-1:0] b_y2_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CoordWidth-1:0] out_x1_o,
  output logic signed [CoordWidth-1:0] out_y1_o,
  output logic signed [CoordWidth-1:0] out_x2_o,
  output logic signed [CoordWidth-1:0] out_y2_o,
  output logic [2:0]                   piece_kind_o,
  output logic                         empty_res_o,
  output logic                         last_o
);

  logic                         s1_valid_q, s1_valid_d;
  logic signed [CoordWidth-1:0] s1_ax1_q, s1_ay1_q, s1_ax2_q, s1_ay2_q;
  logic signed [CoordWidth-1:0] s1_bx1_q, s1_by1_q, s1_bx2_q, s1_by2_q;

  logic                         s2_valid_q, s2_valid_d;
  piece_mask_t                  s2_mask_q, s2_mask_d;
  logic signed [CoordWidth-1:0] s2_ax1_q, s2_ay1_q, s2_ax2_q, s2_ay2_q;
  logic signed [CoordWidth-1:0] s2_bx1_q, s2_by1_q, s2_bx2_q, s2_by2_q;
  logic signed [CoordWidth-1:0] s2_cx1_q, s2_cx2_q, s2_cx1_d, s2_cx2_d;

  logic ser_ready;
  logic s2_ready;
  logic s1_ready;
  logic s1_load;
  logic s2_load;
  logic overlap, lf, rt, lo, up;

  assign s2_ready   = !s2_valid_q || ser_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s1_load    = in_valid_i && s1_ready;
  assign s2_load    = s1_valid_q && s2_ready;

  always_comb begin
    overlap = (s1_ax1_q < s1_bx2_q) && (s1_bx1_q < s1_ax2_q) &&
              (s1_ay1_q < s1_by2_q) && (s1_by1_q < s1_ay2_q);
    lf = s1_ax1_q < s1_bx1_q;
    rt = s1_bx2_q < s1_ax2_q;
    lo = s1_ay1_q < s1_by1_q;
    up = s1_by2_q < s1_ay2_q;
    s2_mask_d.whole = !overlap;
    s2_mask_d.left  = overlap && lf;
    s2_mask_d.right = overlap && rt;
    s2_mask_d.lower = overlap && lo;
    s2_mask_d.upper = overlap && up;
    s2_mask_d.empty = overlap && !(lf || rt || lo || up);
    s2_cx1_d = lf ? s1_bx1_q : s1_ax1_q;
    s2_cx2_d = rt ? s1_bx2_q : s1_ax2_q;
    s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
    s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_ax1_q <= a_x1_i; s1_ay1_q <= a_y1_i; s1_ax2_q <= a_x2_i; s1_ay2_q <= a_y2_i;
      s1_bx1_q <= b_x1_i; s1_by1_q <= b_y1_i; s1_bx2_q <= b_x2_i; s1_by2_q <= b_y2_i;
    end
    if (s2_load) begin
      s2_mask_q <= s2_mask_d;
      s2_ax1_q  <= s1_ax1_q; s2_ay1_q <= s1_ay1_q;
      s2_ax2_q  <= s1_ax2_q; s2_ay2_q <= s1_ay2_q;
      s2_bx1_q  <= s1_bx1_q; s2_by1_q <= s1_by1_q;
      s2_bx2_q  <= s1_bx2_q; s2_by2_q <= s1_by2_q;
      s2_cx1_q  <= s2_cx1_d; s2_cx2_q <= s2_cx2_d;
    end
  end

  rect_sub_serializer #(
    .CoordWidth(CoordWidth)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_ready_o  (ser_ready),
    .mask_i      (s2_mask_q),
    .ax1_i       (s2_ax1_q),
    .ay1_i       (s2_ay1_q),
    .ax2_i       (s2_ax2_q),
    .ay2_i       (s2_ay2_q),
    .bx1_i       (s2_bx1_q),
    .by1_i       (s2_by1_q),
    .bx2_i       (s2_bx2_q),
    .by2_i       (s2_by2_q),
    .cx1_i       (s2_cx1_q),
    .cx2_i       (s2_cx2_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x1_o    (out_x1_o),
    .out_y1_o    (out_y1_o),
    .out_x2_o    (out_x2_o),
    .out_y2_o    (out_y2_o),
    .piece_kind_o(piece_kind_o),
    .empty_res_o (empty_res_o),
    .last_o      (last_o)
  );

endmodule

/* sv/rect_sub_serializer.sv */
// Piece serializer and output register of the rectangle subtract pipeline.
`timescale 1ns / 1ps
`include "rectangle_subtract_assert.svh"

module rect_sub_serializer import rect_sub_pkg::*; #(
  parameter int unsigned CoordWidth = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  piece_mask_t                  mask_i,
  input  logic signed [CoordWidth-1:0] ax1_i,
  input  logic signed [CoordWidth-1:0] ay1_i,
  input  logic signed [CoordWidth-1:0] ax2_i,
  input  logic signed [CoordWidth-1:0] ay2_i,
  input  logic signed [CoordWidth-1:0] bx1_i,
  input  logic signed [CoordWidth-1:0] by1_i,
  input  logic signed [CoordWidth-1:0] bx2_i,
  input  logic signed [CoordWidth-1:0] by2_i,
  input  logic signed [CoordWidth-1:0] cx1_i,
  input  logic signed [CoordWidth-1:0] cx2_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CoordWidth-1:0] out_x1_o,
  output logic signed [CoordWidth-1:0] out_y1_o,
  output logic signed [CoordWidth-1:0] out_x2_o,
  output logic signed [CoordWidth-1:0] out_y2_o,
  output logic [2:0]                   piece_kind_o,
  output logic                         empty_res_o,
  output logic                         last_o
);

  logic                         ser_valid_q, ser_valid_d;
  piece_mask_t                  ser_mask_q, ser_mask_d;
  logic signed [CoordWidth-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic signed [CoordWidth-1:0] bx1_q, by1_q, bx2_q, by2_q;
  logic signed [CoordWidth-1:0] cx1_q, cx2_q;

  logic                         out_valid_q, out_valid_d;
  logic signed [CoordWidth-1:0] ox1_q, oy1_q, ox2_q, oy2_q;
  logic signed [CoordWidth-1:0] ox1_d, oy1_d, ox2_d, oy2_d;
  piece_kind_e                  kind_q, kind_d;
  logic                         empty_q, empty_d;
  logic                         last_q;

  piece_mask_t mask_rem;
  logic        out_load_ok;
  logic        emit;
  logic        ser_last;
  logic        ser_free;
  logic        load;

  assign out_load_ok = !out_valid_q || out_ready_i;
  assign emit        = ser_valid_q && out_load_ok;

  always_comb begin
    mask_rem = ser_mask_q;
    ox1_d    = '0;
    oy1_d    = '0;
    ox2_d    = '0;
    oy2_d    = '0;
    kind_d   = KindWhole;
    empty_d  = 1'b0;
    priority if (ser_mask_q.whole) begin
      mask_rem.whole = 1'b0;
      ox1_d = ax1_q; oy1_d = ay1_q; ox2_d = ax2_q; oy2_d = ay2_q;
    end else if (ser_mask_q.left) begin
      mask_rem.left = 1'b0;
      kind_d = KindLeft;
      ox1_d = ax1_q; oy1_d = ay1_q; ox2_d = bx1_q; oy2_d = ay2_q;
    end else if (ser_mask_q.right) begin
      mask_rem.right = 1'b0;
      kind_d = KindRight;
      ox1_d = bx2_q; oy1_d = ay1_q; ox2_d = ax2_q; oy2_d = ay2_q;
    end else if (ser_mask_q.lower) begin
      mask_rem.lower = 1'b0;
      kind_d = KindLower;
      ox1_d = cx1_q; oy1_d = ay1_q; ox2_d = cx2_q; oy2_d = by1_q;
    end else if (ser_mask_q.upper) begin
      mask_rem.upper = 1'b0;
      kind_d = KindUpper;
      ox1_d = cx1_q; oy1_d = by2_q; ox2_d = cx2_q; oy2_d = ay2_q;
    end else begin
      mask_rem.empty = 1'b0;
      empty_d = 1'b1;
    end
  end

  assign ser_last   = (mask_rem == '0);
  assign ser_free   = !ser_valid_q || (emit && ser_last);
  assign in_ready_o = ser_free;
  assign load       = ser_free && in_valid_i;

  always_comb begin
    ser_valid_d = ser_free ? in_valid_i : ser_valid_q;
    ser_mask_d  = ser_mask_q;
    if (load) begin
      ser_mask_d = mask_i;
    end else if (emit) begin
      ser_mask_d = mask_rem;
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ser_valid_q <= ser_valid_d;
      ser_mask_q  <= ser_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ax1_q <= ax1_i; ay1_q <= ay1_i; ax2_q <= ax2_i; ay2_q <= ay2_i;
      bx1_q <= bx1_i; by1_q <= by1_i; bx2_q <= bx2_i; by2_q <= by2_i;
      cx1_q <= cx1_i; cx2_q <= cx2_i;
    end
    if (emit) begin
      ox1_q   <= ox1_d;
      oy1_q   <= oy1_d;
      ox2_q   <= ox2_d;
      oy2_q   <= oy2_d;
      kind_q  <= kind_d;
      empty_q <= empty_d;
      last_q  <= ser_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x1_o     = ox1_q;
  assign out_y1_o     = oy1_q;
  assign out_x2_o     = ox2_q;
  assign out_y2_o     = oy2_q;
  assign piece_kind_o = kind_q;
  assign empty_res_o  = empty_q;
  assign last_o       = last_q;

  `RS_ASSERT_IMP(a_mask_live, clk_i, rst_ni, ser_valid_q, ser_mask_q != '0)
  `RS_ASSERT_IMP(a_whole_alone, clk_i, rst_ni, ser_valid_q && ser_mask_q.whole,
                 ser_mask_q == piece_mask_t'(6'b000001))
  `RS_ASSERT_NXT(a_ser_hold, clk_i, rst_ni, ser_valid_q && !emit,
                 ser_valid_q && $stable(ser_mask_q))
  `RS_ASSERT_IMP(a_empty_last, clk_i, rst_ni, out_valid_q && empty_q, last_q)

endmodule
